@@ hw/rtl/gradient_magnitude_3x3_core_macros.svh @@
// Assertion macros shared by the gradient magnitude core.
`ifndef GRADIENT_MAGNITUDE_3X3_CORE_MACROS_SVH
`define GRADIENT_MAGNITUDE_3X3_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// Check that a condition implies another in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (prop)) \
		else $error("implication check failed");
// Check that a condition implies another in the following cycle.
`define ASSERT_NEXT(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (prop)) \
		else $error("next-cycle check failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, cond, prop)
`define ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif

`endif

@@ hw/rtl/gm3_pkg.sv @@
package gm3_pkg;

	// Frame geometry limits
	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 4096;

	localparam int PIX_W  = 8;
	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int ROW_W  = $clog2(MAX_HEIGHT);
	localparam int WCFG_W = COL_W + 1;
	localparam int HCFG_W = ROW_W + 1;
	localparam int DIFF_W = PIX_W + 1;

	// Configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = (WCFG_W > HCFG_W) ? WCFG_W : HCFG_W;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

	// Stream data widths, padded to whole bytes
	localparam int TDATA_IN_W  = ((PIX_W + 7) / 8) * 8;
	localparam int TDATA_OUT_W = ((PIX_W + ROW_W + COL_W + 7) / 8) * 8;

	// Work queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// One result to compute: two differences plus its tags
	typedef struct packed {
		logic signed [DIFF_W-1:0] grad_v;
		logic signed [DIFF_W-1:0] grad_h;
		logic [ROW_W-1:0]         row;
		logic [COL_W-1:0]         col;
		logic                     run_last;
		logic                     frame_done;
	} gm3_desc_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_READ,
		F_EMIT
	} gm3_front_state_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_SQUARE,
		B_SUM,
		B_ROOT,
		B_HOLD
	} gm3_back_state_t;

endpackage

@@ hw/rtl/gm3_front.sv @@
module gm3_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [gm3_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [gm3_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [gm3_pkg::TDATA_IN_W-1:0]      s_tdata,
	output logic                                q_push,
	output gm3_pkg::gm3_desc_t                  q_desc,
	input  logic                                q_full
);
	import gm3_pkg::*;

	localparam int RES_UP   = 0;
	localparam int RES_LEFT = 1;
	localparam int RES_SELF = 2;

	function automatic logic signed [DIFF_W-1:0] pix_diff(
		input logic [PIX_W-1:0] a,
		input logic [PIX_W-1:0] b
	);
		logic signed [DIFF_W-1:0] d;
		d = $signed({1'b0, a}) - $signed({1'b0, b});
		return d;
	endfunction

	gm3_front_state_t state_q, state_d;

	logic [WCFG_W-1:0] image_width_q;
	logic [HCFG_W-1:0] image_height_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [2:0]        pending_q;

	// Current item
	logic [PIX_W-1:0] pix_q;
	logic [COL_W-1:0] c_q;
	logic [ROW_W-1:0] r_q;
	logic             last_col_q;

	// Line buffers and the neighbors read from them
	logic [PIX_W-1:0] cur_mem [MAX_WIDTH];
	logic [PIX_W-1:0] abv_mem [MAX_WIDTH];
	logic [PIX_W-1:0] cc_q, cn_q, ac_q, ap_q, cp1_q, cp2_q;
	logic [COL_W-1:0] cur_ra0, cur_ra1;

	logic [WCFG_W-1:0] w_eff;
	logic [HCFG_W-1:0] h_eff;
	logic              last_col, last_row;
	logic              in_xfer, rd2;
	logic [2:0]        sel, rest;
	logic              r_ge1, r_ge2, c_ge1, c_ge2;
	logic [PIX_W-1:0]  ab_a, lf_a, rt_a, ab_b, lf_b, ab_c, lf_c;

	assign cfg_ready = 1'b1;

	// Clamp the frame size to the supported range
	always_comb begin
		if (image_width_q == '0)
			w_eff = WCFG_W'(1);
		else if (image_width_q > WCFG_W'(MAX_WIDTH))
			w_eff = WCFG_W'(MAX_WIDTH);
		else
			w_eff = image_width_q;
		if (image_height_q == '0)
			h_eff = HCFG_W'(1);
		else if (image_height_q > HCFG_W'(MAX_HEIGHT))
			h_eff = HCFG_W'(MAX_HEIGHT);
		else
			h_eff = image_height_q;
	end

	assign last_col = WCFG_W'(col_q) >= (w_eff - WCFG_W'(1));
	assign last_row = HCFG_W'(row_q) >= (h_eff - HCFG_W'(1));
	assign in_xfer  = s_tvalid && s_tready;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= WCFG_W'(MAX_WIDTH);
			image_height_q <= HCFG_W'(1024);
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:  image_width_q  <= cfg_data[WCFG_W-1:0];
				REG_IMAGE_HEIGHT: image_height_q <= cfg_data[HCFG_W-1:0];
				default: ;
			endcase
		end
	end

	// Raster counters and pending results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= F_IDLE;
			col_q     <= '0;
			row_q     <= '0;
			pending_q <= '0;
		end else begin
			state_q <= state_d;
			if (in_xfer) begin
				if (last_col) begin
					col_q <= '0;
					row_q <= last_row ? '0 : row_q + ROW_W'(1);
				end else begin
					col_q <= col_q + COL_W'(1);
				end
				pending_q[RES_UP]   <= row_q != '0;
				pending_q[RES_LEFT] <= last_row && (col_q != '0);
				pending_q[RES_SELF] <= last_row && last_col;
			end else if (q_push) begin
				pending_q <= rest;
			end
		end
	end

	// Hold the accepted item
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			pix_q      <= s_tdata[PIX_W-1:0];
			c_q        <= col_q;
			r_q        <= row_q;
			last_col_q <= last_col;
		end
	end

	// Two read ports on the current row: center pair at accept, left pair in the following cycle
	assign cur_ra0 = in_xfer ? col_q : c_q - COL_W'(1);
	assign cur_ra1 = in_xfer ? col_q + COL_W'(1) : c_q - COL_W'(2);

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			cc_q <= cur_mem[cur_ra0];
			cn_q <= cur_mem[cur_ra1];
			ac_q <= abv_mem[col_q];
			ap_q <= abv_mem[col_q - COL_W'(1)];
		end
		if (rd2) begin
			cp1_q <= cur_mem[cur_ra0];
			cp2_q <= cur_mem[cur_ra1];
			// shift the column: current row moves up, new pixel comes in
			abv_mem[c_q] <= cc_q;
			cur_mem[c_q] <= pix_q;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			F_IDLE: if (s_tvalid) state_d = F_READ;
			F_READ: state_d = (pending_q != '0) ? F_EMIT : F_IDLE;
			F_EMIT: if (q_push && rest == '0) state_d = F_IDLE;
			default: state_d = F_IDLE;
		endcase
	end

	// Control outputs
	always_comb begin
		s_tready = 1'b0;
		rd2      = 1'b0;
		q_push   = 1'b0;
		case (state_q)
			F_IDLE: s_tready = 1'b1;
			F_READ: rd2 = 1'b1;
			F_EMIT: q_push = (pending_q != '0) && !q_full;
			default: ;
		endcase
	end

	// Pick the oldest pending result
	always_comb begin
		if (pending_q[RES_UP])
			sel = 3'b001;
		else if (pending_q[RES_LEFT])
			sel = 3'b010;
		else
			sel = 3'b100;
		rest = pending_q & ~sel;
	end

	assign r_ge1 = r_q != '0;
	assign r_ge2 = r_q > ROW_W'(1);
	assign c_ge1 = c_q != '0;
	assign c_ge2 = c_q > COL_W'(1);

	// Neighbors with border replacement
	assign ab_a = r_ge2 ? ac_q : cc_q;
	assign lf_a = c_ge1 ? ap_q : cc_q;
	assign rt_a = !last_col_q ? cn_q : cc_q;
	assign ab_b = r_ge1 ? ap_q : cp1_q;
	assign lf_b = c_ge2 ? cp2_q : cp1_q;
	assign ab_c = r_ge1 ? cc_q : pix_q;
	assign lf_c = c_ge1 ? cp1_q : pix_q;

	// Build the result descriptor
	always_comb begin
		q_desc.run_last   = rest == '0;
		q_desc.frame_done = 1'b0;
		if (sel[RES_UP]) begin
			q_desc.grad_v = pix_diff(pix_q, ab_a);
			q_desc.grad_h = pix_diff(rt_a, lf_a);
			q_desc.row    = r_q - ROW_W'(1);
			q_desc.col    = c_q;
		end else if (sel[RES_LEFT]) begin
			q_desc.grad_v = pix_diff(cp1_q, ab_b);
			q_desc.grad_h = pix_diff(pix_q, lf_b);
			q_desc.row    = r_q;
			q_desc.col    = c_q - COL_W'(1);
		end else begin
			q_desc.grad_v     = pix_diff(pix_q, ab_c);
			q_desc.grad_h     = pix_diff(pix_q, lf_c);
			q_desc.row        = r_q;
			q_desc.col        = c_q;
			q_desc.frame_done = 1'b1;
		end
	end

endmodule

@@ hw/rtl/gm3_queue.sv @@
module gm3_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  gm3_pkg::gm3_desc_t push_desc,
	output logic               full,
	input  logic               pop,
	output gm3_pkg::gm3_desc_t pop_desc,
	output logic               not_empty
);
	import gm3_pkg::*;

	gm3_desc_t         slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full      = count_q == QCNT_W'(QUEUE_DEPTH);
	assign not_empty = count_q != '0;
	assign pop_desc  = slot_q[rd_ptr_q];

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			if (push && !pop)
				count_q <= count_q + QCNT_W'(1);
			else if (pop && !push)
				count_q <= count_q - QCNT_W'(1);
		end
	end

	// Store entries
	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_desc;
	end

endmodule

@@ hw/rtl/gm3_back.sv @@
module gm3_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             q_valid,
	output logic                             q_pop,
	input  gm3_pkg::gm3_desc_t               q_desc,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [gm3_pkg::TDATA_OUT_W-1:0]  m_tdata,
	output logic                             m_tlast,
	output logic                             m_tuser
);
	import gm3_pkg::*;

	localparam int SQ_W       = 2 * PIX_W;
	localparam int ROOT_STEPS = PIX_W + 1;
	localparam int REM_W      = 2 * ROOT_STEPS;
	localparam int STEP_W     = $clog2(ROOT_STEPS);

	function automatic logic signed [2*DIFF_W-1:0] q_desc_sq(
		input logic signed [DIFF_W-1:0] d
	);
		logic signed [2*DIFF_W-1:0] p;
		p = d * d;
		return p;
	endfunction

	gm3_back_state_t state_q, state_d;

	gm3_desc_t                  desc_q;
	logic [SQ_W-1:0]            sq_v_q, sq_h_q;
	logic [REM_W-1:0]           rem_q, root_q;
	logic [STEP_W-1:0]          step_q;
	logic signed [2*DIFF_W-1:0] prod_v, prod_h;
	logic [REM_W-1:0]           trial_bit, trial;
	logic                       out_free, load_out;
	logic [PIX_W-1:0]           mag;

	logic                   m_tvalid_q;
	logic [PIX_W-1:0]       mag_q;
	logic [ROW_W-1:0]       row_q;
	logic [COL_W-1:0]       col_q;
	logic                   last_q, done_q;

	assign prod_v    = q_desc_sq(desc_q.grad_v);
	assign prod_h    = q_desc_sq(desc_q.grad_h);
	assign trial_bit = REM_W'(1) << {step_q, 1'b0};
	assign trial     = root_q + trial_bit;
	assign out_free  = !m_tvalid_q || m_tready;
	assign mag       = (root_q[REM_W-1:PIX_W] != '0) ? '1 : root_q[PIX_W-1:0];

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			B_IDLE:   if (q_valid) state_d = B_SQUARE;
			B_SQUARE: state_d = B_SUM;
			B_SUM:    state_d = B_ROOT;
			B_ROOT:   if (step_q == '0) state_d = B_HOLD;
			B_HOLD:   if (out_free) state_d = B_IDLE;
			default:  state_d = B_IDLE;
		endcase
	end

	// Control outputs
	always_comb begin
		q_pop    = 1'b0;
		load_out = 1'b0;
		case (state_q)
			B_IDLE: q_pop = q_valid;
			B_HOLD: load_out = out_free;
			default: ;
		endcase
	end

	// State and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= B_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	// Square, sum, then one root bit per cycle
	always_ff @(posedge clk) begin
		if (q_pop)
			desc_q <= q_desc;
		case (state_q)
			B_SQUARE: begin
				sq_v_q <= prod_v[SQ_W-1:0];
				sq_h_q <= prod_h[SQ_W-1:0];
			end
			B_SUM: begin
				rem_q  <= REM_W'(sq_v_q) + REM_W'(sq_h_q);
				root_q <= '0;
				step_q <= STEP_W'(ROOT_STEPS - 1);
			end
			B_ROOT: begin
				if (rem_q >= trial) begin
					rem_q  <= rem_q - trial;
					root_q <= (root_q >> 1) + trial_bit;
				end else begin
					root_q <= root_q >> 1;
				end
				step_q <= step_q - STEP_W'(1);
			end
			default: ;
		endcase
		if (load_out) begin
			mag_q  <= mag;
			row_q  <= desc_q.row;
			col_q  <= desc_q.col;
			last_q <= desc_q.run_last;
			done_q <= desc_q.frame_done;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = TDATA_OUT_W'({col_q, row_q, mag_q});
	assign m_tlast  = last_q;
	assign m_tuser  = done_q;

endmodule

@@ hw/rtl/gradient_magnitude_3x3_core.sv @@
// Channel   Direction  Handshake             Payload
// cfg       in         cfg_valid/cfg_ready   cfg_index, cfg_data (width, height)
// s_        in         s_tvalid/s_tready     pixel
// m_        out        m_tvalid/m_tready     magnitude, row, col; tlast, tuser
//
// The front accepts a pixel, reads its left neighbors and queues the results it
// releases. The back squares, sums and takes the root of each result in its shared
// square root unit, one root bit per cycle, and pops the next result only once the
// last has been handed to the output register.
// Reset clears counters, queue and valid; the line buffers hold no reset.
// A stalled output holds the back; a full queue holds the front and s_tready.
`include "gradient_magnitude_3x3_core_macros.svh"

module gradient_magnitude_3x3_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [gm3_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [gm3_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// bits: pixel [7:0]
	input  logic [gm3_pkg::TDATA_IN_W-1:0]      s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// bits: magnitude [7:0], out_row [19:8], out_col [29:20], zero [31:30]
	output logic [gm3_pkg::TDATA_OUT_W-1:0]     m_tdata,
	output logic                                m_tlast,
	// bits: frame_done [0]
	output logic                                m_tuser
);
	import gm3_pkg::*;

	logic      q_push, q_full, q_pop, q_valid;
	gm3_desc_t push_desc, pop_desc;

	gm3_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.q_push    (q_push),
		.q_desc    (push_desc),
		.q_full    (q_full)
	);

	gm3_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_desc (push_desc),
		.full      (q_full),
		.pop       (q_pop),
		.pop_desc  (pop_desc),
		.not_empty (q_valid)
	);

	gm3_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_pop    (q_pop),
		.q_desc   (pop_desc),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	// Queue never overflows or underflows; frame_done comes with tlast; front works on one pixel at a time
	`ASSERT_IMPLIES(a_push_has_room, clk, arst_n, q_push, !q_full)
	`ASSERT_IMPLIES(a_pop_has_data, clk, arst_n, q_pop, q_valid)
	`ASSERT_IMPLIES(a_done_is_last, clk, arst_n, m_tvalid && m_tuser, m_tlast)
	`ASSERT_NEXT(a_one_pixel_in_flight, clk, arst_n, s_tvalid && s_tready, !s_tready)

endmodule

@@ tb/testbench.sv @@
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import gm3_pkg::*;

	localparam int SETTLE_CYCLES = 80;

	// One expected magnitude with its tags
	typedef struct packed {
		logic [PIX_W-1:0] magnitude;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic             run_last;
		logic             frame_done;
	} grad_result_t;

	typedef enum int {
		RX_OPEN,
		RX_RANDOM,
		RX_SPARSE
	} rx_mode_t;

	typedef enum int {
		STYLE_NOISE,
		STYLE_EXTREME,
		STYLE_RAMP
	} pix_style_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [TDATA_IN_W-1:0]  s_tdata;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [TDATA_OUT_W-1:0] m_tdata;
	logic                   m_tlast;
	logic                   m_tuser;

	// Line stores, counters and geometry of the gradient predictor
	logic [PIX_W-1:0]  line_above [MAX_WIDTH];
	logic [PIX_W-1:0]  line_curr [MAX_WIDTH];
	int unsigned       col_cnt;
	int unsigned       row_cnt;
	logic [WCFG_W-1:0] width_reg;
	logic [HCFG_W-1:0] height_reg;

	grad_result_t pending_magnitudes[$];
	int           error_count = 0;

	// Sender burst control and receiver hold-off request
	int burst_left = 0;
	int gap_max = 0;
	int hold_request = 0;
	int hold_left = 0;
	int mode_left = 0;
	rx_mode_t rx_mode = RX_OPEN;

	gradient_magnitude_3x3_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Map a register value onto the size actually used
	function automatic int unsigned active_span(input int unsigned v, input int unsigned limit);
		if (v == 0) return 1;
		if (v > limit) return limit;
		return v;
	endfunction

	// Floor square root of the summed squared differences, clipped at 255
	function automatic logic [PIX_W-1:0] gradient_magnitude(input int above, input int below,
			input int left, input int right);
		int          dv;
		int          dh;
		int unsigned energy;
		int unsigned root;
		dv = below - above;
		dh = right - left;
		energy = dv * dv + dh * dh;
		root = 0;
		while (root < 255 && (root + 1) * (root + 1) <= energy) root++;
		return PIX_W'(root);
	endfunction

	function automatic grad_result_t make_result(input logic [PIX_W-1:0] mag,
			input int unsigned row, input int unsigned col, input logic fdone);
		grad_result_t res;
		res.magnitude = mag;
		res.row = ROW_W'(row);
		res.col = COL_W'(col);
		res.run_last = 1'b0;
		res.frame_done = fdone;
		return res;
	endfunction

	// Advance the line stores by one pixel and queue the magnitudes it releases
	function automatic void predict_gradients(input logic [PIX_W-1:0] pix);
		int unsigned  w;
		int unsigned  h;
		int unsigned  r;
		int unsigned  c;
		int           ctr;
		int           ab;
		int           lf;
		int           rt;
		bit           at_last_col;
		bit           at_last_row;
		grad_result_t batch [3];
		int           n;
		w = active_span(width_reg, MAX_WIDTH);
		h = active_span(height_reg, MAX_HEIGHT);
		r = row_cnt;
		c = col_cnt;
		at_last_col = (c >= w - 1);
		at_last_row = (r >= h - 1);
		n = 0;

		// pixel directly above is now complete
		if (r >= 1) begin
			ctr = line_curr[c];
			ab = (r >= 2) ? int'(line_above[c]) : ctr;
			lf = (c > 0) ? int'(line_above[c - 1]) : ctr;
			rt = !at_last_col ? int'(line_curr[c + 1]) : ctr;
			batch[n] = make_result(gradient_magnitude(ab, pix, lf, rt), r - 1, c, 1'b0);
			n++;
		end

		line_above[c] = line_curr[c];
		line_curr[c] = pix;

		// bottom row: left neighbor, then the final pixel itself
		if (at_last_row) begin
			if (c >= 1) begin
				ctr = line_curr[c - 1];
				ab = (r >= 1) ? int'(line_above[c - 1]) : ctr;
				lf = (c >= 2) ? int'(line_curr[c - 2]) : ctr;
				batch[n] = make_result(gradient_magnitude(ab, ctr, lf, pix), r, c - 1, 1'b0);
				n++;
			end
			if (at_last_col) begin
				ab = (r >= 1) ? int'(line_above[c]) : int'(pix);
				lf = (c >= 1) ? int'(line_curr[c - 1]) : int'(pix);
				batch[n] = make_result(gradient_magnitude(ab, pix, lf, pix), r, c, 1'b1);
				n++;
			end
		end

		if (n > 0) batch[n - 1].run_last = 1'b1;
		for (int k = 0; k < n; k++) pending_magnitudes.push_back(batch[k]);

		if (at_last_col) begin
			col_cnt = 0;
			row_cnt = at_last_row ? 0 : r + 1;
		end else begin
			col_cnt = c + 1;
		end
	endfunction

	function automatic void compare_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			error_count++;
		end
	endfunction

	function automatic void check_result();
		grad_result_t want;
		if (pending_magnitudes.size() == 0) begin
			$error("result with nothing expected: magnitude %0d row %0d col %0d",
				m_tdata[7:0], m_tdata[19:8], m_tdata[29:20]);
			error_count++;
			return;
		end
		want = pending_magnitudes.pop_front();
		compare_field("magnitude", want.magnitude, m_tdata[7:0]);
		compare_field("out_row", want.row, m_tdata[19:8]);
		compare_field("out_col", want.col, m_tdata[29:20]);
		compare_field("run_last", want.run_last, m_tlast);
		compare_field("frame_done", want.frame_done, m_tuser);
	endfunction

	// Check each transfer out, then pick the next ready value
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) check_result();
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (mode_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 2));
			mode_left = $urandom_range(20, 200);
		end else begin
			mode_left--;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			case (rx_mode)
				RX_OPEN:   m_tready <= 1'b1;
				RX_RANDOM: m_tready <= 1'($urandom_range(0, 1));
				default:   m_tready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// Offer one pixel, hold it until the transfer, then maybe idle for a while
	task automatic send_pixel(input logic [PIX_W-1:0] pix);
		s_tvalid <= 1'b1;
		s_tdata <= pix;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_gradients(pix);
		if (burst_left > 0) begin
			burst_left--;
		end else if (gap_max > 0) begin
			burst_left = $urandom_range(0, 12);
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, gap_max)) @(posedge clk);
		end
	endtask

	// Write both geometry registers back to back
	task automatic set_geometry(input logic [CFG_DATA_W-1:0] w_val,
			input logic [CFG_DATA_W-1:0] h_val);
		cfg_valid <= 1'b1;
		cfg_index <= REG_IMAGE_WIDTH;
		cfg_data <= w_val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		width_reg = w_val[WCFG_W-1:0];
		cfg_index <= REG_IMAGE_HEIGHT;
		cfg_data <= h_val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		height_reg = h_val[HCFG_W-1:0];
		cfg_valid <= 1'b0;
	endtask

	// Hold the sender until every magnitude is back and the block has settled
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending_magnitudes.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [PIX_W-1:0] pick_pixel(input pix_style_t style, input int row,
			input int col);
		case (style)
			STYLE_NOISE:   return PIX_W'($urandom_range(0, 255));
			STYLE_EXTREME: return $urandom_range(0, 1) ? 8'hFF : PIX_W'($urandom_range(0, 3));
			default:       return PIX_W'(row * 37 + col * 23 + $urandom_range(0, 7));
		endcase
	endfunction

	task automatic send_frame(input int w, input int h, input pix_style_t style);
		for (int r = 0; r < h; r++) begin
			for (int c = 0; c < w; c++) send_pixel(pick_pixel(style, r, c));
		end
		wait_idle();
	endtask

	// Full swings in every direction, saturation and all borders of a 3x3 frame
	task automatic test_extreme_pixels();
		logic [PIX_W-1:0] pix [9] = '{8'h00, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'hFF,
			8'hFF, 8'h00, 8'h00};
		gap_max = 3;
		set_geometry(3, 3);
		foreach (pix[k]) send_pixel(pix[k]);
		wait_idle();
	endtask

	// Zero sizes act as one: each pixel is a whole frame
	task automatic test_single_pixel();
		set_geometry(0, 0);
		send_pixel(8'hFF);
		send_pixel(8'h00);
		wait_idle();
	endtask

	task automatic test_single_column();
		set_geometry(1, 3);
		send_pixel(8'hFF);
		send_pixel(8'h00);
		send_pixel(8'h80);
		wait_idle();
	endtask

	task automatic test_single_row();
		set_geometry(4, 1);
		send_pixel(8'h00);
		send_pixel(8'hFF);
		send_pixel(8'h00);
		send_pixel(8'hFF);
		wait_idle();
	endtask

	// Shrink both sizes inside a frame so the current pixel ends it
	task automatic test_resize_mid_frame();
		set_geometry(4, 4);
		for (int k = 0; k < 10; k++) send_pixel(pick_pixel(STYLE_NOISE, 0, 0));
		wait_idle();
		set_geometry(2, 2);
		send_pixel(8'h5A);
		wait_idle();
	endtask

	// Oversized register values clamp to the maximum width
	task automatic test_widest_row();
		gap_max = 4;
		set_geometry(13'h1FFF, 2);
		for (int c = 0; c < 6; c++) send_pixel(pick_pixel(STYLE_NOISE, 0, c));
		wait_idle();
		// narrow the row so the next pixel closes it, then finish the frame
		set_geometry(7, 2);
		for (int c = 0; c < 8; c++) send_pixel(pick_pixel(STYLE_NOISE, 1, c));
		wait_idle();
	endtask

	task automatic test_tallest_column();
		gap_max = 2;
		set_geometry(1, 13'h1FFF);
		for (int r = 0; r < 3; r++) send_pixel(pick_pixel(STYLE_RAMP, r, 0));
		wait_idle();
		// shorten the frame so the next row is the last one
		set_geometry(1, 4);
		send_pixel(pick_pixel(STYLE_RAMP, 3, 0));
		wait_idle();
	endtask

	// Block the output for a long stretch while pixels keep coming
	task automatic test_backpressure();
		gap_max = 0;
		burst_left = 0;
		set_geometry(8, 4);
		hold_request = 400;
		send_frame(8, 4, STYLE_NOISE);
	endtask

	task automatic test_random_frames();
		int         sent;
		int         fw;
		int         fh;
		pix_style_t style;
		sent = 0;
		while (sent < 60) begin
			fw = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 16) : $urandom_range(1, 12);
			fh = $urandom_range(1, 5);
			style = pix_style_t'($urandom_range(0, 2));
			gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
			set_geometry(CFG_DATA_W'(fw), CFG_DATA_W'(fh));
			send_frame(fw, fh, style);
			sent += fw * fh;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		width_reg = WCFG_W'(1024);
		height_reg = HCFG_W'(1024);
		col_cnt = 0;
		row_cnt = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_extreme_pixels();
		test_single_pixel();
		test_single_column();
		test_single_row();
		test_resize_mid_frame();
		test_backpressure();
		test_widest_row();
		test_tallest_column();
		test_random_frames();

		wait_idle();
		if (error_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	// Give up on a hung run
	initial begin
		#10_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule
